FILE: hdl/assert_macros.svh
// assertion macros used by the top-level rtl file of the path validator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked outside reset
`define RPV_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RPV_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RPV_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg)
`define RPV_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

FILE: hdl/rpv_pkg.sv
// types, constants and helper functions of the relative path validator
package rpv_pkg;

    // component length limit and counter width
    localparam int MAX_NAME_BYTES = 1024;
    localparam int NAME_LEN_W     = $clog2(MAX_NAME_BYTES + 1);

    // stem capture: four bytes kept, count saturates at five
    localparam int STEM_KEEP  = 4;
    localparam int STEM_CNT_W = 3;
    localparam logic [STEM_CNT_W-1:0] STEM_SAT = 3'd5;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_HIDDEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_EMPTY  = 1'b1;

    // byte codes
    localparam logic [7:0] CHR_CTRL_LIMIT = 8'h20;
    localparam logic [7:0] CHR_SPACE      = 8'h20;
    localparam logic [7:0] CHR_QUOTE      = 8'h22;
    localparam logic [7:0] CHR_STAR       = 8'h2A;
    localparam logic [7:0] CHR_DOT        = 8'h2E;
    localparam logic [7:0] CHR_SLASH      = 8'h2F;
    localparam logic [7:0] CHR_ONE        = 8'h31;
    localparam logic [7:0] CHR_NINE       = 8'h39;
    localparam logic [7:0] CHR_COLON      = 8'h3A;
    localparam logic [7:0] CHR_LT         = 8'h3C;
    localparam logic [7:0] CHR_GT         = 8'h3E;
    localparam logic [7:0] CHR_QUESTION   = 8'h3F;
    localparam logic [7:0] CHR_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CHR_LOW_A      = 8'h61;
    localparam logic [7:0] CHR_LOW_Z      = 8'h7A;
    localparam logic [7:0] CHR_BAR        = 8'h7C;
    localparam logic [7:0] CASE_OFFSET    = 8'h20;

    // reserved device stems, upper case
    localparam logic [23:0] DEV_CON = 24'h434F4E;
    localparam logic [23:0] DEV_PRN = 24'h50524E;
    localparam logic [23:0] DEV_AUX = 24'h415558;
    localparam logic [23:0] DEV_NUL = 24'h4E554C;
    localparam logic [23:0] DEV_COM = 24'h434F4D;
    localparam logic [23:0] DEV_LPT = 24'h4C5054;

    typedef logic [STEM_KEEP-1:0][7:0] stem_t;

    // classified beat travelling from front to back
    typedef struct packed {
        logic       end_flag;
        logic       slash;
        logic       dot;
        logic       forbidden;
        logic       bad_tail;
        logic [7:0] up_byte;
    } item_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
    } q_status_t;

    typedef struct packed {
        logic pop;
        logic pop_end;
    } bk_status_t;

    // control bytes and the punctuation that portable names exclude
    function automatic logic byte_forbidden(input logic [7:0] b);
        return (b < CHR_CTRL_LIMIT) || (b == CHR_BACKSLASH) || (b == CHR_COLON) ||
               (b == CHR_STAR) || (b == CHR_QUESTION) || (b == CHR_QUOTE) ||
               (b == CHR_LT) || (b == CHR_GT) || (b == CHR_BAR);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        return ((b >= CHR_LOW_A) && (b <= CHR_LOW_Z)) ? (b - CASE_OFFSET) : b;
    endfunction

    // stem names a device: three letters, or COM/LPT plus a digit 1-9
    function automatic logic is_device(input stem_t s, input logic [STEM_CNT_W-1:0] cnt);
        logic [23:0] head;
        logic        three;
        logic        four;
        head  = {s[0], s[1], s[2]};
        three = (cnt == STEM_CNT_W'(3)) &&
                ((head == DEV_CON) || (head == DEV_PRN) ||
                 (head == DEV_AUX) || (head == DEV_NUL));
        four  = (cnt == STEM_CNT_W'(4)) && ((head == DEV_COM) || (head == DEV_LPT)) &&
                (s[3] >= CHR_ONE) && (s[3] <= CHR_NINE);
        return three || four;
    endfunction

endpackage

FILE: hdl/rpv_if.sv
// valid/ready channel interfaces for path beats and verdicts
interface rpv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] path_byte;
    logic       end_of_path;

    modport source (output valid, output path_byte, output end_of_path, input ready);
    modport sink   (input valid, input path_byte, input end_of_path, output ready);
endinterface

interface rpv_out_if;
    logic valid;
    logic ready;
    logic path_ok;

    modport source (output valid, output path_ok, input ready);
    modport sink   (input valid, input path_ok, output ready);
endinterface

FILE: hdl/rpv_front.sv
// front end: accepts path beats and classifies each byte
module rpv_front (
    rpv_in_if.sink          in_ch,
    input  logic            q_full,
    output logic            push,
    output rpv_pkg::item_t  push_item
);
    import rpv_pkg::*;

    // take a beat whenever the queue has room
    assign in_ch.ready = !q_full;
    assign push        = in_ch.valid && !q_full;

    // byte classification
    always_comb
    begin
        push_item.end_flag  = in_ch.end_of_path;
        push_item.slash     = (in_ch.path_byte == CHR_SLASH);
        push_item.dot       = (in_ch.path_byte == CHR_DOT);
        push_item.forbidden = byte_forbidden(in_ch.path_byte);
        push_item.bad_tail  = (in_ch.path_byte == CHR_SPACE) ||
                              (in_ch.path_byte == CHR_DOT);
        push_item.up_byte   = to_upper(in_ch.path_byte);
    end
endmodule

FILE: hdl/rpv_queue.sv
// short fifo of classified beats between front and back
module rpv_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rpv_pkg::item_t     push_item,
    input  logic               pop,
    output logic               head_valid,
    output rpv_pkg::item_t     head_item,
    output rpv_pkg::q_status_t status
);
    import rpv_pkg::*;

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign status.count = count_reg;
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid   = (count_reg != '0);
    assign head_item    = slot_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && head_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule

FILE: hdl/rpv_back.sv
// back end: tracks the current component and issues the verdict beat
module rpv_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                allow_hidden,
    input  logic                allow_empty,
    input  logic                head_valid,
    input  rpv_pkg::item_t      head_item,
    output logic                pop,
    rpv_out_if.source           out_ch,
    output rpv_pkg::bk_status_t status
);
    import rpv_pkg::*;

    logic                  rejected_reg;
    logic                  rejected_next;
    logic                  at_start_reg;
    logic                  at_start_next;
    logic [NAME_LEN_W-1:0] len_reg;
    logic [NAME_LEN_W-1:0] len_next;
    logic                  first_dot_reg;
    logic                  first_dot_next;
    logic                  second_dot_reg;
    logic                  second_dot_next;
    logic                  tail_bad_reg;
    logic                  tail_bad_next;
    stem_t                 stem_reg;
    stem_t                 stem_next;
    logic [STEM_CNT_W-1:0] stem_cnt_reg;
    logic [STEM_CNT_W-1:0] stem_cnt_next;
    logic                  stem_closed_reg;
    logic                  stem_closed_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  path_ok_reg;
    logic                  path_ok_next;
    logic                  out_free;
    logic                  comp_bad;

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.path_ok = path_ok_reg;

    // a terminator needs a free output slot, bytes never wait
    assign out_free = !out_valid_reg || out_ch.ready;
    assign pop      = head_valid && (!head_item.end_flag || out_free);

    assign status.pop     = pop;
    assign status.pop_end = pop && head_item.end_flag;

    // component rules on the running record
    always_comb
    begin
        comp_bad = (len_reg == '0) ||
                   (len_reg >= NAME_LEN_W'(MAX_NAME_BYTES)) ||
                   ((len_reg == NAME_LEN_W'(1)) && first_dot_reg) ||
                   ((len_reg == NAME_LEN_W'(2)) && first_dot_reg && second_dot_reg) ||
                   (first_dot_reg && !allow_hidden) ||
                   tail_bad_reg ||
                   is_device(stem_reg, stem_cnt_reg);
    end

    // next state of the component record and output slot
    always_comb
    begin
        rejected_next    = rejected_reg;
        at_start_next    = at_start_reg;
        len_next         = len_reg;
        first_dot_next   = first_dot_reg;
        second_dot_next  = second_dot_reg;
        tail_bad_next    = tail_bad_reg;
        stem_next        = stem_reg;
        stem_cnt_next    = stem_cnt_reg;
        stem_closed_next = stem_closed_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;
        path_ok_next     = path_ok_reg;

        if (pop)
        begin
            if (head_item.end_flag || head_item.slash)
            begin
                // close the component
                len_next         = '0;
                first_dot_next   = 1'b0;
                second_dot_next  = 1'b0;
                tail_bad_next    = 1'b0;
                stem_next        = '0;
                stem_cnt_next    = '0;
                stem_closed_next = 1'b0;
                if (head_item.end_flag)
                begin
                    out_valid_next = 1'b1;
                    path_ok_next   = at_start_reg ? allow_empty : (!rejected_reg && !comp_bad);
                    rejected_next  = 1'b0;
                    at_start_next  = 1'b1;
                end
                else
                begin
                    at_start_next = 1'b0;
                    if (comp_bad)
                    begin
                        rejected_next = 1'b1;
                    end
                end
            end
            else
            begin
                // ordinary byte
                at_start_next = 1'b0;
                if (head_item.forbidden)
                begin
                    rejected_next = 1'b1;
                end
                if (len_reg == '0)
                begin
                    first_dot_next = head_item.dot;
                end
                if (len_reg == NAME_LEN_W'(1))
                begin
                    second_dot_next = head_item.dot;
                end
                if (len_reg != NAME_LEN_W'(MAX_NAME_BYTES))
                begin
                    len_next = len_reg + 1'b1;
                end
                tail_bad_next = head_item.bad_tail;
                if (head_item.dot)
                begin
                    stem_closed_next = 1'b1;
                end
                else if (!stem_closed_reg)
                begin
                    if (stem_cnt_reg < STEM_CNT_W'(STEM_KEEP))
                    begin
                        stem_next[stem_cnt_reg[1:0]] = head_item.up_byte;
                    end
                    if (stem_cnt_reg != STEM_SAT)
                    begin
                        stem_cnt_next = stem_cnt_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rejected_reg    <= 1'b0;
            at_start_reg    <= 1'b1;
            len_reg         <= '0;
            first_dot_reg   <= 1'b0;
            second_dot_reg  <= 1'b0;
            tail_bad_reg    <= 1'b0;
            stem_cnt_reg    <= '0;
            stem_closed_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            rejected_reg    <= rejected_next;
            at_start_reg    <= at_start_next;
            len_reg         <= len_next;
            first_dot_reg   <= first_dot_next;
            second_dot_reg  <= second_dot_next;
            tail_bad_reg    <= tail_bad_next;
            stem_cnt_reg    <= stem_cnt_next;
            stem_closed_reg <= stem_closed_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        stem_reg    <= stem_next;
        path_ok_reg <= path_ok_next;
    end
endmodule

FILE: hdl/relative_path_validator_core.sv
// relative path validator top level: front, queue, back and config registers
// a terminator beat is queued, then its verdict is registered in the output slot
// throughput: one beat per cycle while the verdict output is not stalled
// a full two-entry queue holds off input only while the verdict output is stalled
// reset: async active low, clears config to zero and the path record to start of path
`include "assert_macros.svh"
module relative_path_validator_core (
    input  logic                               clk,
    input  logic                               rst_n,
    rpv_in_if.sink                             in_ch,
    rpv_out_if.source                          out_ch,
    input  logic                               cfg_we,
    input  logic [rpv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rpv_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rpv_pkg::*;

    logic       allow_hidden_reg;
    logic       allow_empty_reg;
    logic       push;
    item_t      push_item;
    logic       pop;
    logic       head_valid;
    item_t      head_item;
    q_status_t  q_stat;
    bk_status_t bk_stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_hidden_reg <= 1'b0;
            allow_empty_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ALLOW_HIDDEN: allow_hidden_reg <= cfg_data[0];
                REG_ALLOW_EMPTY:  allow_empty_reg  <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // beat intake and classification
    rpv_front u_front (
        .in_ch     (in_ch),
        .q_full    (q_stat.full),
        .push      (push),
        .push_item (push_item)
    );

    // decoupling queue
    rpv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .status     (q_stat)
    );

    // component tracking and verdict
    rpv_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .allow_hidden (allow_hidden_reg),
        .allow_empty  (allow_empty_reg),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (pop),
        .out_ch       (out_ch),
        .status       (bk_stat)
    );

    // queue never holds more than its depth
    `RPV_ASSERT_IMPLY(a_queue_bound, clk, rst_n, 1'b1, q_stat.count <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
    // a verdict only follows a terminator taken by the back
    `RPV_ASSERT_IMPLY(a_verdict_src, clk, rst_n, $rose(out_ch.valid), $past(bk_stat.pop_end), "verdict without terminator")
    // a taken terminator always lands in the output slot
    `RPV_ASSERT_NEXT(a_term_lands, clk, rst_n, bk_stat.pop_end, out_ch.valid, "terminator lost")
endmodule

FILE: sim/path_verdict_checker.sv
// path verdict checker: mirrors the validator state and compares every verdict beat
module path_verdict_checker
    import rpv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    rpv_in_if                     in_ch,
    rpv_out_if                    out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    verdicts_due
);
    timeunit 1ns;
    timeprecision 1ps;

    // mirrored configuration
    logic hidden_ok;
    logic empty_ok;

    // mirrored path record
    logic                  path_bad;
    logic                  fresh_path;
    logic [NAME_LEN_W-1:0] comp_len;
    logic [7:0]            lead0;
    logic [7:0]            lead1;
    logic [7:0]            last_byte;
    logic [7:0]            stem_up [STEM_KEEP];
    logic [STEM_CNT_W-1:0] stem_fill;
    logic                  stem_done;

    // verdicts still owed by the block, oldest first
    logic verdict_q [$];
    int   misses;

    // start a new component
    function automatic void restart_name();
        comp_len  = '0;
        lead0     = '0;
        lead1     = '0;
        last_byte = '0;
        for (int k = 0; k < STEM_KEEP; k++)
            stem_up[k] = '0;
        stem_fill = '0;
        stem_done = 1'b0;
    endfunction

    // byte that a portable name may not hold
    function automatic logic unportable_byte(input logic [7:0] b);
        return b < CHR_CTRL_LIMIT || b == CHR_BACKSLASH || b == CHR_COLON ||
               b == CHR_STAR || b == CHR_QUESTION || b == CHR_QUOTE ||
               b == CHR_LT || b == CHR_GT || b == CHR_BAR;
    endfunction

    // rules applied when a component closes
    function automatic logic comp_rejected();
        logic [23:0] head;
        logic        dev3;
        logic        dev4;
        head = {stem_up[0], stem_up[1], stem_up[2]};
        dev3 = stem_fill == 3 &&
               (head == DEV_CON || head == DEV_PRN || head == DEV_AUX || head == DEV_NUL);
        dev4 = stem_fill == 4 && (head == DEV_COM || head == DEV_LPT) &&
               stem_up[3] >= CHR_ONE && stem_up[3] <= CHR_NINE;
        return comp_len == 0 || comp_len >= MAX_NAME_BYTES ||
               (comp_len == 1 && lead0 == CHR_DOT) ||
               (comp_len == 2 && lead0 == CHR_DOT && lead1 == CHR_DOT) ||
               (lead0 == CHR_DOT && !hidden_ok) ||
               last_byte == CHR_SPACE || last_byte == CHR_DOT || dev3 || dev4;
    endfunction

    function automatic void note_miss(input string what, input logic want, input logic got);
        misses++;
        if (misses <= 10)
            $display("%0t: %s: expected path_ok=%b, got path_ok=%b", $realtime, what, want, got);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic       ok;
        logic [7:0] b;
        if (!rst_n)
        begin
            hidden_ok  = 1'b0;
            empty_ok   = 1'b0;
            path_bad   = 1'b0;
            fresh_path = 1'b1;
            restart_name();
            verdict_q.delete();
            misses = 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ALLOW_HIDDEN: hidden_ok = cfg_data[0];
                    REG_ALLOW_EMPTY:  empty_ok  = cfg_data[0];
                    default: ;
                endcase
            end

            // verdict beat against the oldest expectation
            if (out_ch.valid && out_ch.ready)
            begin
                if (verdict_q.size() == 0)
                    note_miss("verdict with none expected", 1'bx, out_ch.path_ok);
                else
                begin
                    ok = verdict_q.pop_front();
                    if (out_ch.path_ok !== ok)
                        note_miss("verdict mismatch", ok, out_ch.path_ok);
                end
            end

            // path beat updates the record
            if (in_ch.valid && in_ch.ready)
            begin
                b = in_ch.path_byte;
                if (in_ch.end_of_path)
                begin
                    ok = fresh_path ? empty_ok : (!path_bad && !comp_rejected());
                    verdict_q.push_back(ok);
                    path_bad   = 1'b0;
                    fresh_path = 1'b1;
                    restart_name();
                end
                else
                begin
                    fresh_path = 1'b0;
                    if (b == CHR_SLASH)
                    begin
                        if (comp_rejected())
                            path_bad = 1'b1;
                        restart_name();
                    end
                    else
                    begin
                        if (unportable_byte(b))
                            path_bad = 1'b1;
                        if (comp_len == 0)
                            lead0 = b;
                        else if (comp_len == 1)
                            lead1 = b;
                        if (comp_len < MAX_NAME_BYTES)
                            comp_len++;
                        last_byte = b;
                        // stem ends at the first dot, kept upper case
                        if (b == CHR_DOT)
                            stem_done = 1'b1;
                        else if (!stem_done)
                        begin
                            if (stem_fill < STEM_KEEP)
                                stem_up[stem_fill] = (b >= CHR_LOW_A && b <= CHR_LOW_Z) ?
                                                     b - CASE_OFFSET : b;
                            if (stem_fill < STEM_SAT)
                                stem_fill++;
                        end
                    end
                end
            end
        end
        fail_count   <= misses;
        verdicts_due <= verdict_q.size();
    end

endmodule

FILE: sim/tb.sv
// top of the path validator testbench: clock, reset, path stimulus and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rpv_pkg::*;

    typedef logic [7:0] path_t [$];

    localparam int         QUIET_LIMIT    = 5000;
    localparam int         HOLD_CYCLES    = 60;
    localparam int         RANDOM_BEATS   = 70;
    localparam logic [7:0] CHR_DASH       = 8'h2D;
    localparam logic [7:0] CHR_UNDERSCORE = 8'h5F;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int   fail_count;
    int   verdicts_due;
    int   send_gap_pct = 0;
    int   take_gap_pct = 0;
    int   quiet_cycles;
    logic hold_req = 1'b0;

    logic [23:0] dev_names [6] = '{DEV_CON, DEV_PRN, DEV_AUX, DEV_NUL, DEV_COM, DEV_LPT};
    logic [7:0]  odd_bytes [8] = '{CHR_BACKSLASH, CHR_COLON, CHR_STAR, CHR_QUESTION,
                                   CHR_QUOTE, CHR_LT, CHR_GT, CHR_BAR};

    rpv_in_if  path_ch ();
    rpv_out_if verdict_ch ();

    relative_path_validator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (path_ch),
        .out_ch    (verdict_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    path_verdict_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (path_ch),
        .out_ch       (verdict_ch),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .verdicts_due (verdicts_due)
    );

    always #1 clk = ~clk;

    // letters, digits, dash and underscore
    function automatic logic [7:0] plain_char();
        int r;
        r = $urandom_range(63);
        if (r < 26)
            return CHR_LOW_A + 8'(r);
        else if (r < 52)
            return CHR_LOW_A - CASE_OFFSET + 8'(r - 26);
        else if (r < 62)
            return CHR_ONE - 8'd1 + 8'(r - 52);
        else if (r == 62)
            return CHR_DASH;
        return CHR_UNDERSCORE;
    endfunction

    function automatic path_t text_bytes(input string s);
        path_t p;
        for (int i = 0; i < s.len(); i++)
            p.push_back(s[i]);
        return p;
    endfunction

    // one component, mostly well formed, with every rejection kind but overlength mixed in
    function automatic path_t random_component();
        path_t      c;
        int         kind;
        int         pick;
        logic [7:0] ch;
        kind = $urandom_range(99);
        if (kind < 50)
        begin
            repeat ($urandom_range(1, 8)) c.push_back(plain_char());
            if ($urandom_range(3) == 0)
            begin
                c.push_back(CHR_DOT);
                repeat ($urandom_range(1, 3)) c.push_back(plain_char());
            end
        end
        else if (kind < 62)
        begin
            // device stem in mixed case; the last two stems take a digit
            pick = $urandom_range(5);
            for (int j = 0; j < 3; j++)
            begin
                ch = dev_names[pick][23 - 8*j -: 8];
                if ($urandom_range(1))
                    ch = ch + CASE_OFFSET;
                c.push_back(ch);
            end
            if (pick >= 4 || $urandom_range(3) == 0)
                c.push_back(8'($urandom_range(CHR_ONE - 1, CHR_NINE)));
            case ($urandom_range(3))
                0: c.push_back(plain_char());
                1:
                begin
                    c.push_back(CHR_DOT);
                    repeat ($urandom_range(1, 3)) c.push_back(plain_char());
                end
                default: ;
            endcase
        end
        else if (kind < 69)
        begin
            c.push_back(CHR_DOT);
            repeat ($urandom_range(1, 5)) c.push_back(plain_char());
        end
        else if (kind < 74)
            repeat ($urandom_range(1, 2)) c.push_back(CHR_DOT);
        else if (kind < 79)
        begin
            repeat ($urandom_range(1, 5)) c.push_back(plain_char());
            c.push_back($urandom_range(1) ? CHR_SPACE : CHR_DOT);
        end
        else if (kind < 86)
        begin
            repeat ($urandom_range(3)) c.push_back(plain_char());
            if ($urandom_range(1))
                c.push_back(odd_bytes[$urandom_range(7)]);
            else
                c.push_back(8'($urandom_range(CHR_CTRL_LIMIT - 1)));
            repeat ($urandom_range(3)) c.push_back(plain_char());
        end
        else if (kind >= 91)
            repeat ($urandom_range(1, 6)) c.push_back(8'($urandom_range(255)));
        // the rest stay empty
        return c;
    endfunction

    function automatic path_t random_path();
        path_t p;
        path_t comp;
        int    parts;
        if ($urandom_range(19) == 0)
            return p;
        parts = $urandom_range(1, 4);
        for (int k = 0; k < parts; k++)
        begin
            if (k > 0)
                p.push_back(CHR_SLASH);
            comp = random_component();
            foreach (comp[i])
                p.push_back(comp[i]);
        end
        return p;
    endfunction

    // offer one beat, with an optional idle gap first, and wait for acceptance
    task automatic put_beat(input logic [7:0] b, input logic last);
        if ($urandom_range(99) < send_gap_pct)
        begin
            path_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        path_ch.valid       <= 1'b1;
        path_ch.path_byte   <= b;
        path_ch.end_of_path <= last;
        @(posedge clk);
        while (!path_ch.ready)
            @(posedge clk);
    endtask

    // path bytes then a terminator carrying a junk byte
    task automatic send_path(input path_t p);
        foreach (p[i])
            put_beat(p[i], 1'b0);
        put_beat(8'($urandom_range(255)), 1'b1);
    endtask

    // stop sending and wait for every verdict, plus the block latency
    task automatic settle();
        path_ch.valid <= 1'b0;
        @(posedge clk);
        while (verdicts_due != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_regs(input logic hidden, input logic empty);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ALLOW_HIDDEN;
        cfg_data  <= hidden;
        @(posedge clk);
        cfg_index <= REG_ALLOW_EMPTY;
        cfg_data  <= empty;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // verdict receiver: random stalls, or a long hold when asked
    initial
    begin
        verdict_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                verdict_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            verdict_ch.ready <= ($urandom_range(99) >= take_gap_pct);
        end
    end

    // cycles with no beat moving on either channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((path_ch.valid && path_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        @(posedge clk);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        path_t p;
        int    beats;
        rst_n               <= 1'b0;
        path_ch.valid       <= 1'b0;
        path_ch.path_byte   <= '0;
        path_ch.end_of_path <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= REG_ALLOW_HIDDEN;
        cfg_data            <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed paths under reset settings
        send_path(text_bytes(""));
        send_path(text_bytes("a"));
        send_path(text_bytes("/a"));
        send_path(text_bytes("a//b/"));
        send_path(text_bytes("."));
        send_path(text_bytes(".."));
        send_path(text_bytes(".h"));
        send_path(text_bytes("a "));
        send_path(text_bytes("b."));
        send_path(text_bytes("cOm9"));
        send_path(text_bytes("Lpt1.x"));
        send_path(text_bytes("com0"));
        send_path(text_bytes("nul"));
        p = text_bytes("a");
        p.push_back(8'h00);
        p.push_back(8'hFF);
        send_path(p);
        send_path(text_bytes("x\\y|"));

        // both switches on
        settle();
        set_regs(1'b1, 1'b1);
        send_path(text_bytes(""));
        send_path(text_bytes(".h/.."));

        // random phases with their own idling and settings
        for (int ph = 0; ph < 3; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    send_gap_pct = 33;
                    take_gap_pct = 81;
                    set_regs(1'b0, 1'b1);
                end
                1:
                begin
                    send_gap_pct = 81;
                    take_gap_pct = 33;
                    set_regs(1'b1, 1'b0);
                end
                default:
                begin
                    send_gap_pct = 0;
                    take_gap_pct = 0;
                    set_regs(1'b0, 1'b0);
                    // long output hold while paths keep coming
                    hold_req = 1'b1;
                    repeat (8) send_path(random_path());
                end
            endcase
            beats = 0;
            while (beats < RANDOM_BEATS)
            begin
                p = random_path();
                send_path(p);
                beats += p.size() + 1;
            end
        end

        settle();
        if (fail_count == 0 && verdicts_due == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/rpv_pkg.sv
hdl/rpv_if.sv
hdl/rpv_front.sv
hdl/rpv_queue.sv
hdl/rpv_back.sv
hdl/relative_path_validator_core.sv
sim/path_verdict_checker.sv
sim/tb.sv
